@@ design/cre_pkg.sv @@
// Shared types and constants for the competition rank engine.
package cre_pkg;

    localparam int SCORE_W      = 10;
    localparam int POS_W        = 4;
    localparam int RANK_W       = 5;
    localparam int SET_SIZE_DEF = 16;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_RANK  = 4'b0100,
        ST_DRAIN = 4'b1000
    } cre_state_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // move held entries one cell toward the head
        logic prime;   // copy held entry into the circulating slot, clear count
        logic rotate;  // compare, then pass the circulating slot along the ring
    } cre_cell_ctrl_t;

endpackage

@@ design/cre_cell.sv @@
// One cell of the ranking chain: a held score, its greater-count and a ring slot.
module cre_cell #(
    parameter int CNT_W = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cre_pkg::cre_cell_ctrl_t     ctrl,
    input  logic [cre_pkg::SCORE_W-1:0] own_score_in,
    input  logic                        own_valid_in,
    input  logic [CNT_W-1:0]            own_cnt_in,
    output logic [cre_pkg::SCORE_W-1:0] own_score_out,
    output logic                        own_valid_out,
    output logic [CNT_W-1:0]            own_cnt_out,
    input  logic [cre_pkg::SCORE_W-1:0] pass_score_in,
    input  logic                        pass_valid_in,
    output logic [cre_pkg::SCORE_W-1:0] pass_score_out,
    output logic                        pass_valid_out
);
    import cre_pkg::*;

    logic [SCORE_W-1:0] own_score_reg, own_score_next;
    logic               own_valid_reg, own_valid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SCORE_W-1:0] pass_score_reg, pass_score_next;
    logic               pass_valid_reg, pass_valid_next;

    always_comb begin
        own_score_next  = own_score_reg;
        own_valid_next  = own_valid_reg;
        cnt_next        = cnt_reg;
        pass_score_next = pass_score_reg;
        pass_valid_next = pass_valid_reg;
        if (ctrl.shift) begin
            own_score_next = own_score_in;
            own_valid_next = own_valid_in;
            cnt_next       = own_cnt_in;
        end else if (ctrl.prime) begin
            pass_score_next = own_score_reg;
            pass_valid_next = own_valid_reg;
            cnt_next        = '0;
        end else if (ctrl.rotate) begin
            if (pass_valid_reg && own_valid_reg && (pass_score_reg > own_score_reg)) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pass_score_next = pass_score_in;
            pass_valid_next = pass_valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_valid_reg  <= 1'b0;
            pass_valid_reg <= 1'b0;
        end else begin
            own_valid_reg  <= own_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
        own_score_reg  <= own_score_next;
        cnt_reg        <= cnt_next;
        pass_score_reg <= pass_score_next;
    end

    assign own_score_out  = own_score_reg;
    assign own_valid_out  = own_valid_reg;
    assign own_cnt_out    = cnt_reg;
    assign pass_score_out = pass_score_reg;
    assign pass_valid_out = pass_valid_reg;

endmodule

@@ design/competition_rank_engine.sv @@
// Top level of the competition rank engine: cell chain, sequencer and result register.
// Loading: one score word per cycle while s_ready is high; a score beyond SET_SIZE is dropped.
// After the closing word the ring is primed, then rotated so that every cell sees every score.
// Results then leave at one per cycle while m_ready is high, once the empty head cells are skipped.
// Reset (aresetn low, synchronous) empties the chain and the result register; no sweep needed.
module competition_rank_engine #(
    parameter int SET_SIZE = cre_pkg::SET_SIZE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cre_pkg::SCORE_W-1:0] s_score,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cre_pkg::POS_W-1:0]   m_position,
    output logic [cre_pkg::SCORE_W-1:0] m_score_out,
    output logic [cre_pkg::RANK_W-1:0]  m_rank,
    output logic                        m_end_of_run
);
    import cre_pkg::*;

    // counts, indexes and ranks all stay within 0..SET_SIZE
    localparam int CW  = $clog2(SET_SIZE + 1);
    localparam int PWW = CW + POS_W;   // room to truncate position to its field
    localparam int RWW = CW + RANK_W;  // room to form rank, then truncate

    cre_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;   // scores held in the chain
    logic [CW-1:0]  step_reg, step_next;     // rotation counter, then result index

    logic                 m_valid_reg, m_valid_next;
    logic [POS_W-1:0]     m_position_reg, m_position_next;
    logic [SCORE_W-1:0]   m_score_reg, m_score_next;
    logic [RANK_W-1:0]    m_rank_reg, m_rank_next;
    logic                 m_eor_reg, m_eor_next;

    cre_cell_ctrl_t ctrl;

    // chain links: index i is the output of cell i, index SET_SIZE feeds the tail
    logic [SCORE_W-1:0] sh_score [0:SET_SIZE];
    logic               sh_valid [0:SET_SIZE];
    logic [CW-1:0]      sh_cnt   [0:SET_SIZE];
    logic [SCORE_W-1:0] ps_score [0:SET_SIZE-1];
    logic               ps_valid [0:SET_SIZE-1];

    logic in_acc;
    logic store;
    logic out_free;
    logic emit;
    logic last_emit;
    logic [PWW-1:0] pos_wide;
    logic [RWW-1:0] rank_wide;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_acc   = s_valid && s_ready;
    assign store    = in_acc && (count_reg < CW'(SET_SIZE));
    assign out_free = !m_valid_reg || m_ready;

    // head cell feeds the result register; empty head cells are skipped freely
    assign emit      = (state_reg == ST_DRAIN) && sh_valid[0] && out_free;
    assign last_emit = emit && ((step_reg + CW'(1)) == count_reg);

    // tail input: new score while loading, empty slot while draining
    assign sh_score[SET_SIZE] = s_score;
    assign sh_valid[SET_SIZE] = store;
    assign sh_cnt[SET_SIZE]   = '0;

    always_comb begin
        ctrl.shift  = store || ((state_reg == ST_DRAIN) && (!sh_valid[0] || out_free));
        ctrl.prime  = (state_reg == ST_PRIME);
        ctrl.rotate = (state_reg == ST_RANK);
    end

    for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
        cre_cell #(
            .CNT_W (CW)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .own_score_in   (sh_score[i+1]),
            .own_valid_in   (sh_valid[i+1]),
            .own_cnt_in     (sh_cnt[i+1]),
            .own_score_out  (sh_score[i]),
            .own_valid_out  (sh_valid[i]),
            .own_cnt_out    (sh_cnt[i]),
            .pass_score_in  (ps_score[(i+1) % SET_SIZE]),
            .pass_valid_in  (ps_valid[(i+1) % SET_SIZE]),
            .pass_score_out (ps_score[i]),
            .pass_valid_out (ps_valid[i])
        );
    end

    // sequencer: load, prime the ring, rotate SET_SIZE times, drain in arrival order
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_LOAD: begin
                if (store) begin
                    count_next = count_reg + CW'(1);
                end
                if (in_acc && s_last) begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                step_next  = '0;
                state_next = ST_RANK;
            end
            ST_RANK: begin
                if (step_reg == CW'(SET_SIZE - 1)) begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (last_emit) begin
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_LOAD;
                end else if (emit) begin
                    step_next = step_reg + CW'(1);
                end
            end
            default: begin
                state_next = ST_LOAD;
                count_next = '0;
                step_next  = '0;
            end
        endcase
    end

    // result register: load on emit, drop once taken
    assign pos_wide  = PWW'(step_reg);
    assign rank_wide = RWW'(sh_cnt[0]) + RWW'(1);

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_position_next = m_position_reg;
        m_score_next    = m_score_reg;
        m_rank_next     = m_rank_reg;
        m_eor_next      = m_eor_reg;
        if (emit) begin
            m_valid_next    = 1'b1;
            m_position_next = pos_wide[POS_W-1:0];
            m_score_next    = sh_score[0];
            m_rank_next     = rank_wide[RANK_W-1:0];
            m_eor_next      = last_emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        m_position_reg <= m_position_next;
        m_score_reg    <= m_score_next;
        m_rank_reg     <= m_rank_next;
        m_eor_reg      <= m_eor_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_position   = m_position_reg;
    assign m_score_out  = m_score_reg;
    assign m_rank       = m_rank_reg;
    assign m_end_of_run = m_eor_reg;

endmodule

@@ design/cre_checker.sv @@
// Port-level checker for the competition rank engine, bound to the top level.
module cre_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [cre_pkg::SCORE_W-1:0] s_score,
    input logic                        s_last,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cre_pkg::POS_W-1:0]   m_position,
    input logic [cre_pkg::SCORE_W-1:0] m_score_out,
    input logic [cre_pkg::RANK_W-1:0]  m_rank,
    input logic                        m_end_of_run
);
    import cre_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position) && $stable(m_score_out)
                                   && $stable(m_rank) && $stable(m_end_of_run)))
        else $error("result word changed while stalled");

    // results of one run stream without gaps, positions counting up
    a_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_end_of_run) |=>
            (m_valid && (m_position == ($past(m_position) + 4'd1))))
        else $error("gap or position skip inside a run");

    // no loading while a run still has results to deliver
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_end_of_run) |-> !s_ready)
        else $error("input accepted during a run");

    // a word that does not close the set keeps the block loading
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last) |=> s_ready)
        else $error("loading stopped without a closing word");

endmodule

bind competition_rank_engine cre_checker u_cre_checker (.*);
